// File: rtl/svf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svf_pkg
// Shared widths, register indexes, filter modes and the command struct for
// the oversampled state-variable filter.
// ----------------------------------------------------------------------------
package svf_pkg;

    localparam int SAMPLE_BITS    = 16;
    localparam int COEF_FRAC_BITS = 16;
    localparam int ACC_FRAC_BITS  = 24 - SAMPLE_BITS;
    localparam int NODE_W         = 32;
    localparam int FREQ_W         = 17;
    localparam int DAMP_W         = 18;
    localparam int MODE_W         = 2;
    localparam int CFG_W          = 18;
    localparam int CFG_IDX_W      = 2;

    // coefficient (zero-extended, signed) times node
    localparam int PROD_W   = DAMP_W + 1 + NODE_W;
    localparam int RND_W    = PROD_W + 1 - COEF_FRAC_BITS;
    localparam int SUM_W    = RND_W + 1;
    localparam int TAPSUM_W = NODE_W + 1;
    localparam int OUTR_W   = TAPSUM_W + 1;
    localparam int Y_W      = OUTR_W - ACC_FRAC_BITS - 1;

    localparam logic [PROD_W:0]   PROD_HALF = (PROD_W + 1)'(1) << (COEF_FRAC_BITS - 1);
    localparam logic [OUTR_W-1:0] OUT_HALF  = OUTR_W'(1) << ACC_FRAC_BITS;

    localparam logic [CFG_IDX_W-1:0] REG_FREQ = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DAMP = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MODE = 2'd2;

    localparam logic [MODE_W-1:0] MODE_LP    = 2'd0;
    localparam logic [MODE_W-1:0] MODE_HP    = 2'd1;
    localparam logic [MODE_W-1:0] MODE_BP    = 2'd2;
    localparam logic [MODE_W-1:0] MODE_NOTCH = 2'd3;

    localparam logic [FREQ_W-1:0] FREQ_RESET = 17'd0;
    localparam logic [DAMP_W-1:0] DAMP_RESET = 18'd111411;
    localparam logic [MODE_W-1:0] MODE_RESET = MODE_HP;

    typedef enum logic [1:0] {
        MUL_DAMP_BP,
        MUL_FREQ_BP,
        MUL_FREQ_HP
    } mul_sel_t;

    typedef struct packed {
        logic     load_x;
        logic     mul_en;
        mul_sel_t mul_sel;
        logic     upd_notch;
        logic     upd_lp;
        logic     upd_hp;
        logic     upd_bp;
        logic     tap_first;
        logic     tap_add;
        logic     out_load;
    } svf_cmd_t;

endpackage

// File: rtl/svf_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svf_ctrl
// Sequencer for the two filter passes and the input/output handshakes.
// ----------------------------------------------------------------------------
module svf_ctrl
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    output logic                out_valid,
    input  logic                out_stall,
    output svf_pkg::svf_cmd_t   cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_MD,
        S_MF,
        S_LP,
        S_HP,
        S_MH,
        S_BP,
        S_TAP,
        S_OUT
    } state_t;

    state_t state_reg, state_next;
    logic   pass_reg, pass_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_free;

    assign out_free  = !out_valid_reg || !out_stall;
    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        cmd            = '0;
        cmd.mul_sel    = svf_pkg::MUL_DAMP_BP;
        state_next     = state_reg;
        pass_next      = pass_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_x = 1'b1;
                    pass_next  = 1'b0;
                    state_next = S_MD;
                end
            end
            S_MD:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = svf_pkg::MUL_DAMP_BP;
                state_next  = S_MF;
            end
            S_MF:
            begin
                cmd.upd_notch = 1'b1;
                cmd.mul_en    = 1'b1;
                cmd.mul_sel   = svf_pkg::MUL_FREQ_BP;
                state_next    = S_LP;
            end
            S_LP:
            begin
                cmd.upd_lp = 1'b1;
                state_next = S_HP;
            end
            S_HP:
            begin
                cmd.upd_hp = 1'b1;
                state_next = S_MH;
            end
            S_MH:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = svf_pkg::MUL_FREQ_HP;
                state_next  = S_BP;
            end
            S_BP:
            begin
                cmd.upd_bp = 1'b1;
                state_next = S_TAP;
            end
            S_TAP:
            begin
                if (!pass_reg)
                begin
                    cmd.tap_first = 1'b1;
                    pass_next     = 1'b1;
                    state_next    = S_MD;
                end
                else
                begin
                    cmd.tap_add = 1'b1;
                    state_next  = S_OUT;
                end
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            pass_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pass_reg      <= pass_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// File: rtl/svf_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svf_datapath
// Coefficient registers, shared multiplier, filter nodes and output rounding.
// ----------------------------------------------------------------------------
module svf_datapath
(
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    cfg_we,
    input  logic [svf_pkg::CFG_IDX_W-1:0]           cfg_index,
    input  logic [svf_pkg::CFG_W-1:0]               cfg_data,
    input  logic signed [svf_pkg::SAMPLE_BITS-1:0]  sample_in,
    input  svf_pkg::svf_cmd_t                       cmd,
    output logic signed [svf_pkg::SAMPLE_BITS-1:0]  sample_out
);

    function automatic logic signed [svf_pkg::RND_W-1:0] round_prod(
        input logic signed [svf_pkg::PROD_W-1:0] p
    );
        logic [svf_pkg::PROD_W:0] t;
        t = {p[svf_pkg::PROD_W-1], p} + svf_pkg::PROD_HALF;
        return t[svf_pkg::PROD_W:svf_pkg::COEF_FRAC_BITS];
    endfunction

    function automatic logic signed [svf_pkg::NODE_W-1:0] sat_node(
        input logic signed [svf_pkg::SUM_W-1:0] v
    );
        logic [svf_pkg::SUM_W-svf_pkg::NODE_W:0] top;
        top = v[svf_pkg::SUM_W-1:svf_pkg::NODE_W-1];
        if ((&top) || !(|top))
        begin
            return v[svf_pkg::NODE_W-1:0];
        end
        else if (v[svf_pkg::SUM_W-1])
        begin
            return {1'b1, {(svf_pkg::NODE_W-1){1'b0}}};
        end
        else
        begin
            return {1'b0, {(svf_pkg::NODE_W-1){1'b1}}};
        end
    endfunction

    function automatic logic signed [svf_pkg::SUM_W-1:0] ext_node(
        input logic signed [svf_pkg::NODE_W-1:0] n
    );
        return {{(svf_pkg::SUM_W-svf_pkg::NODE_W){n[svf_pkg::NODE_W-1]}}, n};
    endfunction

    logic [svf_pkg::FREQ_W-1:0]              freq_reg;
    logic [svf_pkg::DAMP_W-1:0]              damp_reg;
    logic [svf_pkg::MODE_W-1:0]              mode_reg;
    logic signed [svf_pkg::SAMPLE_BITS-1:0]  x_reg;
    logic signed [svf_pkg::PROD_W-1:0]       prod_reg;
    logic signed [svf_pkg::NODE_W-1:0]       notch_reg, notch_next;
    logic signed [svf_pkg::NODE_W-1:0]       lp_reg, lp_next;
    logic signed [svf_pkg::NODE_W-1:0]       hp_reg, hp_next;
    logic signed [svf_pkg::NODE_W-1:0]       bp_reg, bp_next;
    logic signed [svf_pkg::TAPSUM_W-1:0]     sum_reg;
    logic signed [svf_pkg::SAMPLE_BITS-1:0]  out_reg, out_next;

    logic signed [svf_pkg::DAMP_W:0]         coef_op;
    logic signed [svf_pkg::NODE_W-1:0]       node_op;
    logic signed [svf_pkg::RND_W-1:0]        rnd;
    logic signed [svf_pkg::SUM_W-1:0]        rnd_ext;
    logic signed [svf_pkg::SUM_W-1:0]        x_ext;
    logic signed [svf_pkg::NODE_W-1:0]       tap;
    logic signed [svf_pkg::TAPSUM_W-1:0]     tap_ext;
    logic [svf_pkg::OUTR_W-1:0]              out_round;
    logic [svf_pkg::Y_W-1:0]                 y;
    logic [svf_pkg::Y_W-svf_pkg::SAMPLE_BITS:0] y_top;

    // multiplier operands
    always_comb
    begin
        unique case (cmd.mul_sel)
            svf_pkg::MUL_DAMP_BP:
            begin
                coef_op = {1'b0, damp_reg};
                node_op = bp_reg;
            end
            svf_pkg::MUL_FREQ_BP:
            begin
                coef_op = {{(svf_pkg::DAMP_W-svf_pkg::FREQ_W+1){1'b0}}, freq_reg};
                node_op = bp_reg;
            end
            svf_pkg::MUL_FREQ_HP:
            begin
                coef_op = {{(svf_pkg::DAMP_W-svf_pkg::FREQ_W+1){1'b0}}, freq_reg};
                node_op = hp_reg;
            end
            default:
            begin
                coef_op = {1'b0, damp_reg};
                node_op = bp_reg;
            end
        endcase
    end

    assign rnd     = round_prod(prod_reg);
    assign rnd_ext = {{(svf_pkg::SUM_W-svf_pkg::RND_W){rnd[svf_pkg::RND_W-1]}}, rnd};
    assign x_ext   = {{(svf_pkg::SUM_W-svf_pkg::SAMPLE_BITS-svf_pkg::ACC_FRAC_BITS)
                       {x_reg[svf_pkg::SAMPLE_BITS-1]}},
                      x_reg, {svf_pkg::ACC_FRAC_BITS{1'b0}}};

    assign notch_next = sat_node(x_ext - rnd_ext);
    assign lp_next    = sat_node(ext_node(lp_reg) + rnd_ext);
    assign hp_next    = sat_node(ext_node(notch_reg) - ext_node(lp_reg));
    assign bp_next    = sat_node(ext_node(bp_reg) + rnd_ext);

    always_comb
    begin
        unique case (mode_reg)
            svf_pkg::MODE_LP:    tap = lp_reg;
            svf_pkg::MODE_HP:    tap = hp_reg;
            svf_pkg::MODE_BP:    tap = bp_reg;
            svf_pkg::MODE_NOTCH: tap = notch_reg;
            default:             tap = notch_reg;
        endcase
    end

    assign tap_ext = {tap[svf_pkg::NODE_W-1], tap};

    // average of both passes, round half up, saturate
    assign out_round = {sum_reg[svf_pkg::TAPSUM_W-1], sum_reg} + svf_pkg::OUT_HALF;
    assign y         = out_round[svf_pkg::OUTR_W-1:svf_pkg::ACC_FRAC_BITS+1];
    assign y_top     = y[svf_pkg::Y_W-1:svf_pkg::SAMPLE_BITS-1];

    always_comb
    begin
        if ((&y_top) || !(|y_top))
        begin
            out_next = y[svf_pkg::SAMPLE_BITS-1:0];
        end
        else if (y[svf_pkg::Y_W-1])
        begin
            out_next = {1'b1, {(svf_pkg::SAMPLE_BITS-1){1'b0}}};
        end
        else
        begin
            out_next = {1'b0, {(svf_pkg::SAMPLE_BITS-1){1'b1}}};
        end
    end

    // configuration and integrators
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            freq_reg <= svf_pkg::FREQ_RESET;
            damp_reg <= svf_pkg::DAMP_RESET;
            mode_reg <= svf_pkg::MODE_RESET;
            lp_reg   <= '0;
            bp_reg   <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    svf_pkg::REG_FREQ: freq_reg <= cfg_data[svf_pkg::FREQ_W-1:0];
                    svf_pkg::REG_DAMP: damp_reg <= cfg_data[svf_pkg::DAMP_W-1:0];
                    svf_pkg::REG_MODE: mode_reg <= cfg_data[svf_pkg::MODE_W-1:0];
                    default:           ;
                endcase
            end
            if (cmd.upd_lp)
            begin
                lp_reg <= lp_next;
            end
            if (cmd.upd_bp)
            begin
                bp_reg <= bp_next;
            end
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        if (cmd.load_x)
        begin
            x_reg <= sample_in;
        end
        if (cmd.mul_en)
        begin
            prod_reg <= coef_op * node_op;
        end
        if (cmd.upd_notch)
        begin
            notch_reg <= notch_next;
        end
        if (cmd.upd_hp)
        begin
            hp_reg <= hp_next;
        end
        if (cmd.tap_first)
        begin
            sum_reg <= tap_ext;
        end
        else if (cmd.tap_add)
        begin
            sum_reg <= sum_reg + tap_ext;
        end
        if (cmd.out_load)
        begin
            out_reg <= out_next;
        end
    end

    assign sample_out = out_reg;

endmodule

// File: rtl/state_variable_filter_2x.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// state_variable_filter_2x
// Twice-oversampled Chamberlin state-variable filter, one sample in, one out.
// ----------------------------------------------------------------------------
// Each accepted sample runs two filter passes on one shared 19x32 multiplier;
// a pass runs three multiplies and the node updates that depend on them in
// turn. The result is then rounded into the output register once that is
// free, and the block returns to idle, where alone it takes a new sample. A
// finished result waits in the output register while the next sample is
// already taken. The user must write coefficients and mode only while idle;
// the block does not enforce it. The integrators clear at reset.
module state_variable_filter_2x
(
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    cfg_we,
    input  logic [svf_pkg::CFG_IDX_W-1:0]           cfg_index,
    input  logic [svf_pkg::CFG_W-1:0]               cfg_data,
    input  logic                                    in_valid,
    output logic                                    in_stall,
    input  logic signed [svf_pkg::SAMPLE_BITS-1:0]  sample_in,
    output logic                                    out_valid,
    input  logic                                    out_stall,
    output logic signed [svf_pkg::SAMPLE_BITS-1:0]  sample_out
);

    svf_pkg::svf_cmd_t cmd;

    svf_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd)
    );

    svf_datapath u_datapath
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .sample_in  (sample_in),
        .cmd        (cmd),
        .sample_out (sample_out)
    );

endmodule

// File: rtl/svf_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svf_checker
// Port-level checks on the filter handshakes, bound to the top level.
// ----------------------------------------------------------------------------
module svf_checker
(
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    in_valid,
    input  logic                                    in_stall,
    input  logic                                    out_valid,
    input  logic                                    out_stall,
    input  logic signed [svf_pkg::SAMPLE_BITS-1:0]  sample_out
);

    // idle and empty once reset has been seen at an edge
    a_reset_idle: assert property (@(posedge clk)
        !rst_n |=> (!out_valid && !in_stall))
        else $error("outputs not idle during reset");

    // one sample at a time: busy right after an input transfer
    a_busy_after_in: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("input taken while a sample is in work");

    // a new result coincides with the return to idle
    a_result_frees_input: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> !in_stall)
        else $error("result shown while still busy");

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(sample_out)))
        else $error("stalled result changed or dropped");

endmodule

bind state_variable_filter_2x svf_checker u_svf_checker
(
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .sample_out (sample_out)
);
